// ----- hdl/ntctm_pkg.sv -----
// ntctm_pkg: shared types, constants and the thermistor code table
// for the ntc trimmed mean temperature lookup unit. No dependencies.
package ntctm_pkg;

  localparam int CODE_W   = 12;
  localparam int SUM_W    = 15;
  localparam int EXT_W    = 13;
  localparam int IDX_W    = 7;
  localparam int ROM_ROWS = 106;

  // divide by six as multiply by ceil(2^18 / 6) and shift; exact below 2^15
  localparam int          RECIP_SHIFT = 18;
  localparam logic [15:0] RECIP_SIX   = 16'd43691;
  localparam int          PROD_W      = SUM_W + 16;

  localparam logic [CODE_W-1:0] CODE_MAX = 12'hFFF;

  // one row per degree, low bound of the code range
  localparam logic [CODE_W-1:0] NTC_LOW [ROM_ROWS] = '{
    12'd427,  12'd447,  12'd471,  12'd496,  12'd522,  12'd549,  12'd573,  12'd594,
    12'd615,  12'd637,  12'd659,  12'd684,  12'd712,  12'd740,  12'd768,  12'd798,
    12'd828,  12'd860,  12'd891,  12'd923,  12'd957,  12'd990,  12'd1025, 12'd1059,
    12'd1095, 12'd1131, 12'd1167, 12'd1204, 12'd1241, 12'd1278, 12'd1316, 12'd1355,
    12'd1394, 12'd1434, 12'd1473, 12'd1513, 12'd1553, 12'd1593, 12'd1633, 12'd1673,
    12'd1713, 12'd1754, 12'd1794, 12'd1835, 12'd1876, 12'd1916, 12'd1957, 12'd1997,
    12'd2038, 12'd2078, 12'd2117, 12'd2156, 12'd2195, 12'd2233, 12'd2271, 12'd2309,
    12'd2346, 12'd2383, 12'd2419, 12'd2455, 12'd2491, 12'd2525, 12'd2559, 12'd2593,
    12'd2626, 12'd2658, 12'd2691, 12'd2723, 12'd2754, 12'd2785, 12'd2815, 12'd2844,
    12'd2873, 12'd2901, 12'd2929, 12'd2956, 12'd2984, 12'd3011, 12'd3038, 12'd3064,
    12'd3089, 12'd3114, 12'd3138, 12'd3161, 12'd3184, 12'd3207, 12'd3229, 12'd3250,
    12'd3271, 12'd3292, 12'd3312, 12'd3331, 12'd3350, 12'd3369, 12'd3387, 12'd3405,
    12'd3422, 12'd3439, 12'd3455, 12'd3471, 12'd3486, 12'd3501, 12'd3516, 12'd3531,
    12'd3545, 12'd3559
  };

  // one row per degree, high bound of the code range
  localparam logic [CODE_W-1:0] NTC_HIGH [ROM_ROWS] = '{
    12'd447,  12'd471,  12'd496,  12'd522,  12'd548,  12'd572,  12'd593,  12'd614,
    12'd636,  12'd659,  12'd684,  12'd711,  12'd739,  12'd768,  12'd797,  12'd828,
    12'd859,  12'd891,  12'd923,  12'd956,  12'd990,  12'd1024, 12'd1059, 12'd1094,
    12'd1131, 12'd1166, 12'd1203, 12'd1241, 12'd1278, 12'd1316, 12'd1354, 12'd1394,
    12'd1433, 12'd1473, 12'd1513, 12'd1553, 12'd1592, 12'd1633, 12'd1672, 12'd1713,
    12'd1753, 12'd1794, 12'd1835, 12'd1875, 12'd1916, 12'd1956, 12'd1997, 12'd2037,
    12'd2078, 12'd2119, 12'd2159, 12'd2198, 12'd2238, 12'd2277, 12'd2315, 12'd2354,
    12'd2391, 12'd2429, 12'd2465, 12'd2502, 12'd2537, 12'd2572, 12'd2606, 12'd2640,
    12'd2673, 12'd2706, 12'd2739, 12'd2771, 12'd2802, 12'd2833, 12'd2863, 12'd2892,
    12'd2921, 12'd2949, 12'd2976, 12'd3003, 12'd3031, 12'd3058, 12'd3084, 12'd3110,
    12'd3135, 12'd3160, 12'd3183, 12'd3207, 12'd3229, 12'd3251, 12'd3273, 12'd3294,
    12'd3314, 12'd3335, 12'd3354, 12'd3373, 12'd3392, 12'd3410, 12'd3428, 12'd3445,
    12'd3462, 12'd3478, 12'd3493, 12'd3509, 12'd3523, 12'd3538, 12'd3553, 12'd3567,
    12'd3581, 12'd3594
  };

  // commands from controller to datapath
  typedef struct packed {
    logic accept;       // a sample transfer happens this cycle
    logic trim;         // register sum minus extremes, clear the group
    logic scale;        // register the reciprocal product
    logic load_avg;     // register the saturated average, start the search
    logic search_step;  // test one search distance
  } ntctm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_sample;  // the next good sample closes the group
    logic search_done;  // hit, clamp or last distance this cycle
  } ntctm_status_t;

  // rows past the end of the table read the last row
  function automatic logic [IDX_W-1:0] rom_row(input logic [IDX_W-1:0] row);
    logic [IDX_W-1:0] r;
    r = (row >= IDX_W'(ROM_ROWS)) ? IDX_W'(ROM_ROWS - 1) : row;
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] rom_low(input logic [IDX_W-1:0] row);
    return NTC_LOW[rom_row(row)];
  endfunction

  function automatic logic [CODE_W-1:0] rom_high(input logic [IDX_W-1:0] row);
    return NTC_HIGH[rom_row(row)];
  endfunction

endpackage

// ----- hdl/ntctm_datapath.sv -----
// ntctm_datapath: sample accumulator, trimmed mean divide and table search.
// Depends on ntctm_pkg; driven by ntctm_ctrl through ntctm_cmd_t.
module ntctm_datapath #(
  parameter int SAMPLES_PER_RESULT = 8,
  parameter int TABLE_ENTRIES      = 106
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ntctm_pkg::ntctm_cmd_t        cmd,
  output ntctm_pkg::ntctm_status_t     status,
  input  logic [ntctm_pkg::CODE_W-1:0] sample_code,
  input  logic                         sample_ok,
  output logic [ntctm_pkg::CODE_W-1:0] average_code,
  output logic [ntctm_pkg::IDX_W-1:0]  temperature_c,
  output logic                         matched
);
  import ntctm_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_RESULT > 2) ? $clog2(SAMPLES_PER_RESULT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SAMPLES_PER_RESULT - 1);
  localparam logic [IDX_W-1:0] DIST_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0]   ROW_LAST  = (IDX_W + 1)'(TABLE_ENTRIES - 1);

  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  running_sum;
  logic [CODE_W-1:0] smallest_sample;
  logic [CODE_W-1:0] largest_sample;
  logic [SUM_W-1:0]  trimmed;
  logic [PROD_W-1:0] product;
  logic [IDX_W-1:0]  search_dist;

  logic [EXT_W-1:0]  extremes;
  logic [PROD_W-RECIP_SHIFT-1:0] quotient;
  logic [IDX_W:0]    up_row;
  logic [IDX_W-1:0]  dn_row;
  logic              up_hit;
  logic              dn_hit;
  logic              clamp_hit;

  assign status.last_sample = (sample_count == CNT_LAST);

  // accumulate good samples, a failed one clears the group but keeps the count
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      running_sum     <= '0;
      smallest_sample <= '0;
      largest_sample  <= '0;
    end else if (cmd.trim) begin
      sample_count    <= '0;
      running_sum     <= '0;
      smallest_sample <= '0;
      largest_sample  <= '0;
    end else if (cmd.accept) begin
      if (!sample_ok) begin
        running_sum     <= '0;
        smallest_sample <= '0;
        largest_sample  <= '0;
      end else begin
        running_sum <= running_sum + SUM_W'(sample_code);
        if (!status.last_sample) begin
          sample_count <= sample_count + CNT_W'(1);
        end
        if (largest_sample == '0) begin
          largest_sample  <= sample_code;
          smallest_sample <= sample_code;
        end else if (sample_code > largest_sample) begin
          largest_sample <= sample_code;
        end else if (sample_code < smallest_sample) begin
          smallest_sample <= sample_code;
        end
      end
    end
  end

  // trim extremes, saturating at zero, then divide by six and saturate at full scale
  assign extremes = EXT_W'(largest_sample) + EXT_W'(smallest_sample);
  assign quotient = product[PROD_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      trimmed <= (running_sum > SUM_W'(extremes)) ? running_sum - SUM_W'(extremes) : '0;
    end
    if (cmd.scale) begin
      product <= PROD_W'(trimmed) * PROD_W'(RECIP_SIX);
    end
    if (cmd.load_avg) begin
      average_code <= (quotient > (PROD_W - RECIP_SHIFT)'(CODE_MAX)) ?
                      CODE_MAX : quotient[CODE_W-1:0];
    end
  end

  // outward search, row above before row below, top clamp last
  assign up_row    = {1'b0, temperature_c} + {1'b0, search_dist};
  assign dn_row    = temperature_c - search_dist;
  assign up_hit    = (up_row <= ROW_LAST) &&
                     (average_code >= rom_low(up_row[IDX_W-1:0])) &&
                     (average_code <= rom_high(up_row[IDX_W-1:0]));
  assign dn_hit    = (search_dist <= temperature_c) &&
                     (average_code >= rom_low(dn_row)) &&
                     (average_code <= rom_high(dn_row));
  assign clamp_hit = (average_code >= rom_high(DIST_LAST));

  assign status.search_done = up_hit || dn_hit || clamp_hit || (search_dist == DIST_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_c <= '0;
      matched       <= 1'b0;
      search_dist   <= '0;
    end else if (cmd.load_avg) begin
      matched     <= 1'b0;
      search_dist <= '0;
    end else if (cmd.search_step) begin
      if (up_hit) begin
        temperature_c <= up_row[IDX_W-1:0];
        matched       <= 1'b1;
      end else if (dn_hit) begin
        temperature_c <= dn_row;
        matched       <= 1'b1;
      end else if (clamp_hit) begin
        temperature_c <= DIST_LAST;
        matched       <= 1'b1;
      end else begin
        search_dist <= search_dist + IDX_W'(1);
      end
    end
  end

endmodule

// ----- hdl/ntctm_ctrl.sv -----
// ntctm_ctrl: sequencing state machine for the ntc temperature unit.
// Depends on ntctm_pkg; commands ntctm_datapath.
module ntctm_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic                     sample_ok,
  output logic                     result_valid,
  input  logic                     result_stall,
  input  ntctm_pkg::ntctm_status_t status,
  output ntctm_pkg::ntctm_cmd_t    cmd
);
  import ntctm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TRIM   = 3'd1;
  localparam logic [2:0] ST_SCALE  = 3'd2;
  localparam logic [2:0] ST_AVG    = 3'd3;
  localparam logic [2:0] ST_SEARCH = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign sample_stall = (state != ST_IDLE);
  assign result_valid = (state == ST_DONE);

  assign cmd.accept      = (state == ST_IDLE) && sample_valid;
  assign cmd.trim        = (state == ST_TRIM);
  assign cmd.scale       = (state == ST_SCALE);
  assign cmd.load_avg    = (state == ST_AVG);
  assign cmd.search_step = (state == ST_SEARCH);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid && sample_ok && status.last_sample) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM:   state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_AVG;
      ST_AVG:    state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (status.search_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/ntc_trimmed_mean_temperature_lookup_unit.sv -----
// A sample that does not close a group leaves the unit ready for the next one.
// The sample that closes a group of SAMPLES_PER_RESULT good samples starts the
// trim, the multiply by the reciprocal of six and the saturation, each
// registered in its own state, and then the table search, which tests one
// distance per cycle with two table rows each; the result then stays on the
// output until its transfer, and no sample is taken meanwhile, so a
// group-closing sample holds off the next sample transfer through these steps,
// the search and the wait on result_stall.
// A failed conversion clears the partial sum and extremes but not the count.
//
// ntc_trimmed_mean_temperature_lookup_unit: top level of the unit.
// Depends on ntctm_pkg, ntctm_ctrl and ntctm_datapath.
module ntc_trimmed_mean_temperature_lookup_unit #(
  parameter int SAMPLES_PER_RESULT = 8,
  parameter int TABLE_ENTRIES      = 106
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [ntctm_pkg::CODE_W-1:0] sample_code,
  input  logic                         sample_ok,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [ntctm_pkg::CODE_W-1:0] average_code,
  output logic [ntctm_pkg::IDX_W-1:0]  temperature_c,
  output logic                         matched
);
  import ntctm_pkg::*;

  ntctm_cmd_t    cmd;
  ntctm_status_t status;

  // sequencing
  ntctm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_ok    (sample_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // accumulate, divide, search
  ntctm_datapath #(
    .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
    .TABLE_ENTRIES      (TABLE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_code   (sample_code),
    .sample_ok     (sample_ok),
    .average_code  (average_code),
    .temperature_c (temperature_c),
    .matched       (matched)
  );

endmodule

// ----- tb/ntc_trimmed_mean_temperature_lookup_unit_tb.sv -----
`timescale 1ns / 100ps
// ntc_trimmed_mean_temperature_lookup_unit_tb: self-checking bench for the
// ntc trimmed mean temperature lookup unit, with its own group filter and table
// search predictor. Depends on ntctm_pkg and the unit's rtl.
module ntc_trimmed_mean_temperature_lookup_unit_tb;
  import ntctm_pkg::*;

  localparam int GROUP_SIZE    = 8;
  localparam int TABLE_ROWS    = 106;
  localparam int TOP_ROW       = TABLE_ROWS - 1;
  localparam int TRIM_DIV      = 6;
  localparam int CLAMP_CODE    = int'(NTC_HIGH[TOP_ROW]);
  localparam int SAMPLE_TARGET = 1300;
  localparam int SETTLE_CYCLES = 4 + TABLE_ROWS + 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTED   = 100;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              ok;
  } adc_sample_t;

  typedef struct packed {
    logic [CODE_W-1:0] average_code;
    logic [IDX_W-1:0]  temperature_c;
    logic              matched;
  } reading_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  logic [CODE_W-1:0] sample_code  = '0;
  logic              sample_ok    = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [CODE_W-1:0] average_code;
  logic [IDX_W-1:0]  temperature_c;
  logic              matched;

  adc_sample_t sample_backlog[$];
  reading_t    awaited_readings[$];

  int   mismatches    = 0;
  int   samples_sent  = 0;
  int   readings_seen = 0;
  int   cycle_count   = 0;
  int   send_hold     = 0;
  int   stall_left    = 0;
  logic sender_busy   = 1'b0;

  // filter state as the unit should hold it
  logic [3:0]        grp_count;
  logic [SUM_W-1:0]  grp_sum;
  logic [CODE_W-1:0] grp_min;
  logic [CODE_W-1:0] grp_max;
  logic [IDX_W-1:0]  last_temp;

  ntc_trimmed_mean_temperature_lookup_unit #(
    .SAMPLES_PER_RESULT(GROUP_SIZE),
    .TABLE_ENTRIES     (TABLE_ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_code  (sample_code),
    .sample_ok    (sample_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average_code (average_code),
    .temperature_c(temperature_c),
    .matched      (matched)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  // row test with rows outside the table skipped and rows past the rom reading the last
  function automatic bit row_covers(input int row, input int code);
    int r;
    if (row < 0 || row > TOP_ROW) return 1'b0;
    r = (row >= ROM_ROWS) ? ROM_ROWS - 1 : row;
    return code >= int'(NTC_LOW[r]) && code <= int'(NTC_HIGH[r]);
  endfunction

  // fold one accepted sample into the group; a closing sample yields a reading
  task automatic absorb_sample(input logic [CODE_W-1:0] code, input logic ok);
    int       extremes;
    int       trimmed;
    int       base;
    int       d;
    bit       hit;
    reading_t r;
    if (!ok) begin
      grp_sum = '0;
      grp_min = '0;
      grp_max = '0;
      return;
    end
    // an empty largest sample means the group holds nothing yet
    if (grp_max == '0) begin
      grp_max = code;
      grp_min = code;
    end else if (code > grp_max) begin
      grp_max = code;
    end else if (code < grp_min) begin
      grp_min = code;
    end
    grp_sum = grp_sum + code;
    if (int'(grp_count) + 1 < GROUP_SIZE) begin
      grp_count = grp_count + 1'b1;
      return;
    end
    // drop extremes, saturate at zero, divide by six and saturate at full scale
    extremes = int'(grp_max) + int'(grp_min);
    trimmed  = (int'(grp_sum) > extremes) ? (int'(grp_sum) - extremes) / TRIM_DIV : 0;
    if (trimmed > int'(CODE_MAX)) trimmed = int'(CODE_MAX);
    // outward search, row above before row below, top clamp after both
    base = int'(last_temp);
    hit  = 1'b0;
    for (d = 0; d < TABLE_ROWS && !hit; d++) begin
      if (row_covers(base + d, trimmed)) begin
        last_temp = IDX_W'(base + d);
        hit = 1'b1;
      end else if (row_covers(base - d, trimmed)) begin
        last_temp = IDX_W'(base - d);
        hit = 1'b1;
      end else if (trimmed >= CLAMP_CODE) begin
        last_temp = IDX_W'(TOP_ROW);
        hit = 1'b1;
      end
    end
    grp_sum   = '0;
    grp_min   = '0;
    grp_max   = '0;
    grp_count = '0;
    r.average_code  = CODE_W'(trimmed);
    r.temperature_c = last_temp;
    r.matched       = hit;
    awaited_readings.push_back(r);
  endtask

  function automatic logic [CODE_W-1:0] clip_code(input int v);
    if (v < 0) return '0;
    if (v > int'(CODE_MAX)) return CODE_MAX;
    return CODE_W'(v);
  endfunction

  task automatic queue_sample(input logic [CODE_W-1:0] code, input logic ok);
    adc_sample_t s;
    s.code = code;
    s.ok   = ok;
    sample_backlog.push_back(s);
  endtask

  // eight good samples around a center, optionally with one timed-out conversion
  task automatic queue_group(input int center, input int spread, input int fail_at);
    int i;
    for (i = 0; i < GROUP_SIZE; i++) begin
      if (i == fail_at) queue_sample(CODE_W'($urandom), 1'b0);
      queue_sample(clip_code(center + int'($urandom_range(0, 2 * spread)) - spread), 1'b1);
    end
  endtask

  // sample driver: takes one transfer, then idles or presents the next sample
  always @(posedge clk) begin
    adc_sample_t next_item;
    if (rst) begin
      sample_valid <= 1'b0;
      sender_busy = 1'b0;
      send_hold   = 0;
      grp_count   = '0;
      grp_sum     = '0;
      grp_min     = '0;
      grp_max     = '0;
      last_temp   = '0;
    end else begin
      if (sample_valid && !sample_stall) begin
        absorb_sample(sample_code, sample_ok);
        samples_sent++;
        sender_busy = 1'b0;
      end
      if (!sender_busy) begin
        if (send_hold > 0) begin
          send_hold--;
          sample_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          next_item = sample_backlog.pop_front();
          sample_code  <= next_item.code;
          sample_ok    <= next_item.ok;
          sample_valid <= 1'b1;
          sender_busy = 1'b1;
          // some stretches run back to back
          send_hold = ((samples_sent / 96) % 4 == 0) ? 0 : $urandom_range(0, 4);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // reading monitor: checks each transfer, then stalls the next one a while
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (result_valid) begin
      if (!result_stall) begin
        readings_seen++;
        if (awaited_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected reading avg=%0d temp=%0d matched=%0b",
                                    average_code, temperature_c, matched));
        end else begin
          want = awaited_readings.pop_front();
          if (average_code !== want.average_code)
            report_mismatch($sformatf("reading %0d average_code %0d, expected %0d",
                                      readings_seen, average_code, want.average_code));
          if (temperature_c !== want.temperature_c)
            report_mismatch($sformatf("reading %0d temperature_c %0d, expected %0d",
                                      readings_seen, temperature_c, want.temperature_c));
          if (matched !== want.matched)
            report_mismatch($sformatf("reading %0d matched %0b, expected %0b",
                                      readings_seen, matched, want.matched));
        end
        stall_left = ((readings_seen / 8) % 4 == 0) ? 0 : $urandom_range(0, 4);
      end else begin
        stall_left--;
      end
      result_stall <= (stall_left > 0);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ntc_trimmed_mean_temperature_lookup_unit_tb NOT OK");
    $finish;
  end

  initial begin
    int pick;
    int center;
    int spread;
    int fail_at;
    int k;
    int anchor;
    int i;

    // full scale group: clamps to the top row
    queue_group(int'(CODE_MAX), 0, -1);
    // zero seeds the extremes and is replaced by the next sample; no row matches
    queue_sample('0, 1'b1);
    for (i = 0; i < 7; i++) queue_sample(CODE_W'(447), 1'b1);
    // timeout late in a group leaves the sum below the extremes
    for (i = 0; i < 7; i++) queue_sample(CODE_W'(3000), 1'b1);
    queue_sample(CODE_MAX, 1'b0);
    queue_sample(CODE_W'(2000), 1'b1);

    // random groups, drifting or jumping, with some noise samples between
    anchor = 2000;
    while (sample_backlog.size() < SAMPLE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_sample(CODE_W'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        spread = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 64));
        if (pick < 45) begin
          center = anchor + int'($urandom_range(0, 80)) - 40;
        end else if (pick < 80) begin
          center = $urandom_range(0, 4095);
        end else if (pick < 92) begin
          // range bounds give or take one code, including the overlapping ones
          k = $urandom_range(0, TOP_ROW);
          center = ($urandom_range(0, 1) ? int'(NTC_HIGH[k]) : int'(NTC_LOW[k]))
                   + int'($urandom_range(0, 2)) - 1;
          spread = 0;
        end else begin
          center = $urandom_range(0, 1) ? int'($urandom_range(0, 60))
                                        : int'($urandom_range(3560, 4095));
        end
        fail_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, GROUP_SIZE - 1)) : -1;
        queue_group(center, spread, fail_at);
        anchor = int'(clip_code(center));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (sample_backlog.size() != 0 || sender_busy) @(posedge clk);
    while (awaited_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ntc_trimmed_mean_temperature_lookup_unit_tb OK");
    end else begin
      $display("ntc_trimmed_mean_temperature_lookup_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
